// ----- rtl/core/deq_pkg.sv -----
// Shared types and constants for the double-ended queue with search.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] word_t;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_SEARCH     = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    cmd_t  cmd;
    word_t value;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    word_t            data;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] occupancy;
  } out_item_t;

  // What a storage cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_mode_t;

endpackage

// ----- rtl/core/deq_cell.sv -----
// One storage cell of the queue chain; takes a new word or a neighbor's word.
module deq_cell (
  input  logic                clk,
  input  deq_pkg::cell_mode_t mode,
  input  deq_pkg::word_t      prev_data,
  input  deq_pkg::word_t      next_data,
  input  deq_pkg::word_t      load_data,
  output deq_pkg::word_t      data
);

  deq_pkg::word_t data_r;
  deq_pkg::word_t data_nxt;

  always_comb begin
    unique case (mode)
      deq_pkg::CELL_LOAD:      data_nxt = load_data;
      deq_pkg::CELL_FROM_PREV: data_nxt = prev_data;
      deq_pkg::CELL_FROM_NEXT: data_nxt = next_data;
      default:                 data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/core/double_ended_queue_with_search.sv -----
// Top level of the bounded double-ended queue with a linear search.
//
// Commands arrive on the in_ channel (in_valid, in_stall, in_data) and every
// command yields exactly one result on the out_ channel (out_valid,
// out_stall, out_data). A transfer happens at a rising edge where valid is
// high and stall is low.
//
// Entries live in a chain of cells ordered from the front: cell 0 holds the
// front entry. A push at the front shifts the chain toward the back, a pop
// at the front shifts it toward the front, a push at the back loads only the
// cell just past the current tail, and a pop at the back changes no cell.
//
// For push, pop and unused command codes the result is in the output register
// in the cycle after the input transfer, and a new command can be taken
// every cycle while no result is stalled. A search rotates the whole chain
// once, comparing the key against cell 0 at each step, then posts the result
// once the output register is free; the input is stalled for the whole search.
//
// After reset the queue is empty and no result is pending. While the output
// register holds a result that the receiver stalls, the input is stalled.
module double_ended_queue_with_search (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [deq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [deq_pkg::IDX_W-1:0]   step_r, step_nxt;
  deq_pkg::word_t              key_r, key_nxt;
  logic                        found_r, found_nxt;
  logic [deq_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  logic                        out_valid_r, out_valid_nxt;
  deq_pkg::out_item_t          out_r, out_nxt;

  deq_pkg::word_t              cell_q [deq_pkg::DEPTH];
  deq_pkg::cell_mode_t         cell_mode [deq_pkg::DEPTH];
  deq_pkg::cell_mode_t         shift_mode;
  logic                        back_load;

  logic                        out_free;
  logic                        in_fire;
  logic                        full;
  logic                        empty;
  logic [deq_pkg::IDX_W-1:0]   back_idx;
  deq_pkg::out_item_t          res;

  // The output register can take a new result when it is empty or when its
  // current result transfers in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_fire  = in_valid && !in_stall;

  assign full     = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty    = (count_r == '0);
  assign back_idx = deq_pkg::IDX_W'(count_r - deq_pkg::CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    shift_mode    = deq_pkg::CELL_HOLD;
    back_load     = 1'b0;
    res           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res.status = deq_pkg::ST_OK;
          case (in_data.cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                res.status = deq_pkg::ST_FULL;
              end else begin
                shift_mode = deq_pkg::CELL_FROM_PREV;
                count_nxt  = count_r + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                res.status = deq_pkg::ST_FULL;
              end else begin
                back_load = 1'b1;
                count_nxt = count_r + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                res.status = deq_pkg::ST_EMPTY;
              end else begin
                // The old front wraps to the last cell, which is past the tail.
                res.data   = cell_q[0];
                shift_mode = deq_pkg::CELL_FROM_NEXT;
                count_nxt  = count_r - deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                res.status = deq_pkg::ST_EMPTY;
              end else begin
                res.data  = cell_q[back_idx];
                count_nxt = count_r - deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::CMD_SEARCH: begin
              key_nxt   = in_data.value;
              step_nxt  = '0;
              found_nxt = 1'b0;
              pos_nxt   = '0;
              state_nxt = S_SEARCH;
            end
            default: ;
          endcase
          res.occupancy = count_nxt;
          if (in_data.cmd != deq_pkg::CMD_SEARCH) begin
            out_valid_nxt = 1'b1;
            out_nxt       = res;
          end
        end
      end
      S_SEARCH: begin
        // A full rotation leaves every cell where it started.
        shift_mode = deq_pkg::CELL_FROM_NEXT;
        if (!found_r && ({1'b0, step_r} < count_r) && (cell_q[0] == key_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r;
        end
        if (step_r == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + deq_pkg::IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          res.status    = found_r ? deq_pkg::ST_OK : deq_pkg::ST_NOT_FOUND;
          res.position  = pos_r;
          res.occupancy = count_r;
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r  <= step_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

  // The cell chain: cell 0 is the front, the last cell wraps to cell 0 so a
  // shift toward the front doubles as a rotation.
  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_pkg::word_t prev_w;
    deq_pkg::word_t next_w;

    if (i == 0) begin : g_first
      assign prev_w = in_data.value;
    end else begin : g_mid_prev
      assign prev_w = cell_q[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign next_w = cell_q[0];
    end else begin : g_mid_next
      assign next_w = cell_q[i+1];
    end

    assign cell_mode[i] = (back_load && (count_r == deq_pkg::CNT_W'(i))) ?
                          deq_pkg::CELL_LOAD : shift_mode;

    deq_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode[i]),
      .prev_data (prev_w),
      .next_data (next_w),
      .load_data (in_data.value),
      .data      (cell_q[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/deq_checker.sv -----
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input deq_pkg::out_item_t out_data
);

  // A stalled result stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No new command is taken while a stalled result waits.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input open while a result is stalled");

  // A pop on an empty queue leaves it empty and returns no data.
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == deq_pkg::ST_EMPTY) |->
      (out_data.occupancy == '0) && (out_data.data == '0))
    else $error("empty result with entries or data");

  // A refused push only happens with every slot in use.
  a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == deq_pkg::ST_FULL) |->
      (out_data.occupancy == deq_pkg::CNT_W'(deq_pkg::DEPTH)))
    else $error("full result below capacity");

  // A failed search reports neither data nor a position.
  a_miss_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == deq_pkg::ST_NOT_FOUND) |->
      (out_data.position == '0) && (out_data.data == '0))
    else $error("not-found result with position or data");

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
